### rtl/core/vnm_pkg.sv
// Shared pipeline timing constants for the vector normalizer.
`default_nettype none
package vnm_pkg;
  // Registers between the magnitude stage and the square-root input (square, sum).
  localparam int unsigned PRE_SQRT_STAGES = 2;
  // Divider front stage plus the sign/output register.
  localparam int unsigned DIV_EXTRA_STAGES = 2;
endpackage
`default_nettype wire

### rtl/core/vnm_sqrt.sv
// Pipelined floor square root, one root bit per stage.
`default_nettype none
module vnm_sqrt #(
  parameter int unsigned COMPONENT_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic [2*COMPONENT_BITS-1:0]   sum,
  output logic      [COMPONENT_BITS-1:0]     root
);
  import vnm_pkg::*;

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned SUM_W = 2 * CB;
  localparam int unsigned REM_W = CB + 1;

  logic [SUM_W-1:0] rad   [0:CB];
  logic [REM_W-1:0] rem   [0:CB];
  logic [CB-1:0]    rt    [0:CB];

  assign rad[0] = sum;
  assign rem[0] = '0;
  assign rt[0]  = '0;

  // One compare-subtract per stage on the next radicand bit pair
  for (genvar k = 0; k < CB; k++) begin : g_stage
    logic [REM_W+1:0] rem_t;
    logic [REM_W+1:0] trial;
    logic             ge;
    assign rem_t = {rem[k], rad[k][SUM_W-1 -: 2]};
    assign trial = {1'b0, rt[k], 2'b01};
    assign ge    = (rem_t >= trial);
    always_ff @(posedge clk) begin
      rad[k+1] <= {rad[k][SUM_W-3:0], 2'b00};
      if (ge) begin
        rem[k+1] <= REM_W'(rem_t - trial);
        rt[k+1]  <= {rt[k][CB-2:0], 1'b1};
      end else begin
        rem[k+1] <= REM_W'(rem_t);
        rt[k+1]  <= {rt[k][CB-2:0], 1'b0};
      end
    end
  end

  assign root = rt[CB];
endmodule
`default_nettype wire

### rtl/core/vnm_lane.sv
// One component lane: magnitude, square, delay line and pipelined divider.
`default_nettype none
module vnm_lane #(
  parameter int unsigned COMPONENT_BITS = 24,
  parameter int unsigned FRACTION_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic [COMPONENT_BITS-1:0]     comp,
  input  wire logic [COMPONENT_BITS-1:0]     root,
  output logic      [2*COMPONENT_BITS-2:0]   square,
  output logic      [FRACTION_BITS+1:0]      unit
);
  import vnm_pkg::*;

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned DLY   = CB + PRE_SQRT_STAGES;
  localparam int unsigned Q_W   = FB + 1;
  localparam int unsigned U_W   = FB + 2;

  logic [CB-1:0] mag;
  logic          neg;
  logic [CB-1:0] mag_dly [0:DLY-1];
  logic          neg_dly [0:DLY-1];

  // Magnitude and sign of the component
  always_ff @(posedge clk) begin
    neg <= comp[CB-1];
    mag <= comp[CB-1] ? CB'(~comp + 1'b1) : comp;
  end

  // Square for the length sum
  logic [2*CB-1:0] sq_full;
  assign sq_full = mag * mag;
  always_ff @(posedge clk) begin
    square <= sq_full[2*CB-2:0];
  end

  // Hold magnitude and sign until the root arrives
  always_ff @(posedge clk) begin
    mag_dly[0] <= mag;
    neg_dly[0] <= neg;
    for (int i = 1; i < DLY; i++) begin
      mag_dly[i] <= mag_dly[i-1];
      neg_dly[i] <= neg_dly[i-1];
    end
  end

  // Restoring divider: integer bit first, then one fraction bit per stage
  logic [CB-1:0]  drem [0:FB];
  logic [Q_W-1:0] dq   [0:FB];
  logic [CB-1:0]  dm   [0:FB];
  logic           dneg [0:FB];

  always_ff @(posedge clk) begin
    dm[0]   <= root;
    dneg[0] <= neg_dly[DLY-1];
    if (mag_dly[DLY-1] >= root) begin
      drem[0] <= mag_dly[DLY-1] - root;
      dq[0]   <= Q_W'(1);
    end else begin
      drem[0] <= mag_dly[DLY-1];
      dq[0]   <= '0;
    end
  end

  for (genvar s = 1; s <= FB; s++) begin : g_div
    logic [CB:0] r2;
    assign r2 = {drem[s-1], 1'b0};
    always_ff @(posedge clk) begin
      dm[s]   <= dm[s-1];
      dneg[s] <= dneg[s-1];
      if (r2 >= {1'b0, dm[s-1]}) begin
        drem[s] <= CB'(r2 - {1'b0, dm[s-1]});
        dq[s]   <= {dq[s-1][Q_W-2:0], 1'b1};
      end else begin
        drem[s] <= r2[CB-1:0];
        dq[s]   <= {dq[s-1][Q_W-2:0], 1'b0};
      end
    end
  end

  // Apply sign; zero root means zero vector
  logic [U_W-1:0] qx;
  assign qx = {1'b0, dq[FB]};
  always_ff @(posedge clk) begin
    if (dm[FB] == '0) begin
      unit <= '0;
    end else if (dneg[FB]) begin
      unit <= U_W'(~qx + 1'b1);
    end else begin
      unit <= qx;
    end
  end
endmodule
`default_nettype wire

### rtl/core/vector_normalize_magnitude.sv
// Top level of the 3D fixed-point vector normalizer.
//
// Usage: drive vec_x/vec_y/vec_z (signed fixed point, FRACTION_BITS fraction)
// and pulse start. A transaction is taken on each clock edge with start high
// and busy low; busy is never raised, so one vector can enter every cycle.
// Each vector yields one result, presented for exactly one cycle with done
// high: unit_x/unit_y/unit_z (signed, 1.0 = 2^FRACTION_BITS), length (floor
// square root of the squared length) and zero_length.
// The pipeline is one magnitude stage, square and sum stages, one square-root
// stage per root bit, one divider stage per quotient bit plus the integer bit,
// and a sign/output register. Throughput is one vector per cycle: three lanes
// divide side by side, sharing one pipelined square-root unit.
// A zero vector gives zero units and length with zero_length set.
// Reset clears the valid pipeline; in-flight transactions are dropped.
// The receiver cannot stall; results must be captured when done is high.
`default_nettype none
module vector_normalize_magnitude #(
  parameter int unsigned COMPONENT_BITS = 24,
  parameter int unsigned FRACTION_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [COMPONENT_BITS-1:0]  vec_x,
  input  wire logic signed [COMPONENT_BITS-1:0]  vec_y,
  input  wire logic signed [COMPONENT_BITS-1:0]  vec_z,
  output logic                                   done,
  output logic signed [FRACTION_BITS+1:0]        unit_x,
  output logic signed [FRACTION_BITS+1:0]        unit_y,
  output logic signed [FRACTION_BITS+1:0]        unit_z,
  output logic        [COMPONENT_BITS-1:0]       length,
  output logic                                   zero_length
);
  import vnm_pkg::*;

  localparam int unsigned CB      = COMPONENT_BITS;
  localparam int unsigned FB      = FRACTION_BITS;
  localparam int unsigned SQ_W    = 2 * CB - 1;
  localparam int unsigned SUM_W   = 2 * CB;
  localparam int unsigned OUT_DLY = FB + DIV_EXTRA_STAGES;
  localparam int unsigned LAT     = 1 + PRE_SQRT_STAGES + CB + OUT_DLY;

  assign busy = 1'b0;

  logic [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic [SUM_W-1:0] sum;
  logic [CB-1:0]    root;
  logic [FB+1:0]    ux, uy, uz;

  vnm_lane #(.COMPONENT_BITS(CB), .FRACTION_BITS(FB)) u_lane_x (
    .clk(clk), .comp(vec_x), .root(root), .square(sq_x), .unit(ux));
  vnm_lane #(.COMPONENT_BITS(CB), .FRACTION_BITS(FB)) u_lane_y (
    .clk(clk), .comp(vec_y), .root(root), .square(sq_y), .unit(uy));
  vnm_lane #(.COMPONENT_BITS(CB), .FRACTION_BITS(FB)) u_lane_z (
    .clk(clk), .comp(vec_z), .root(root), .square(sq_z), .unit(uz));

  // Merge lanes into the squared length
  always_ff @(posedge clk) begin
    sum <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  end

  vnm_sqrt #(.COMPONENT_BITS(CB)) u_sqrt (
    .clk(clk), .sum(sum), .root(root));

  // Carry the root alongside the lane dividers
  logic [CB-1:0] root_dly [0:OUT_DLY-1];
  always_ff @(posedge clk) begin
    root_dly[0] <= root;
    for (int i = 1; i < OUT_DLY; i++) begin
      root_dly[i] <= root_dly[i-1];
    end
  end

  assign unit_x      = ux;
  assign unit_y      = uy;
  assign unit_z      = uz;
  assign length      = root_dly[OUT_DLY-1];
  assign zero_length = (root_dly[OUT_DLY-1] == '0);

  // Transaction valid pipeline
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end
  assign done = vld[LAT-1];

  // Checks
  a_accept_tracked: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> vld[0]) else $error("accepted transaction not tracked");
  a_zero_units: assert property (@(posedge clk) disable iff (rst)
    (done && zero_length) |-> (unit_x == '0 && unit_y == '0 && unit_z == '0))
    else $error("zero vector with nonzero unit output");
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (done && !zero_length) |-> (length != '0)) else $error("zero flag mismatch");
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("busy raised");
endmodule
`default_nettype wire
